// ----- src/cde_pkg.sv -----
// ----------------------------------------------------------------------------
// Circular deque engine package
// Shared widths, request codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package cde_pkg;

  localparam int unsigned DEPTH      = 256;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned SLOT_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = SLOT_W + 1;
  localparam int unsigned REQ_W      = 4;
  localparam int unsigned IN_TDATA_W = 40;
  localparam int unsigned OUT_TDATA_W = 88;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 4'd0,
    REQ_PUSH_FRONT = 4'd1,
    REQ_POP_BACK   = 4'd2,
    REQ_POP_FRONT  = 4'd3,
    REQ_PEEK_FRONT = 4'd4,
    REQ_PEEK_BACK  = 4'd5,
    REQ_NEXT       = 4'd6,
    REQ_PREV       = 4'd7,
    REQ_FREE_REGS  = 4'd8,
    REQ_USED_REGS  = 4'd9
  } req_e;

  // Controller to datapath
  typedef struct packed {
    logic latch;  // capture the accepted item
    logic exec;   // commit pointers, issue the memory access
    logic load;   // move the result into the output register
  } cde_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // output register empty or draining this cycle
  } cde_sts_t;

endpackage

// ----- src/cde_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cde_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- src/cde_ctrl.sv -----
// ----------------------------------------------------------------------------
// Circular deque engine controller
// Sequences one item through capture, execute and result load.
// ----------------------------------------------------------------------------
module cde_ctrl
  import cde_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  cde_sts_t sts_i,
  output cde_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_WAIT;
      end
      ST_WAIT: begin
        // hold the result until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> cmd_o.exec)
    else $error("accepted item not executed next cycle");

  a_exec_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> !in_ready_o)
    else $error("input ready while result pending");

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.latch, cmd_o.exec, cmd_o.load}))
    else $error("overlapping controller commands");

endmodule

// ----- src/cde_dp.sv -----
// ----------------------------------------------------------------------------
// Circular deque engine datapath
// Ring pointers, capacity register, slot memory and output register.
// ----------------------------------------------------------------------------
module cde_dp
  import cde_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cde_cmd_t          cmd_i,
  output cde_sts_t          sts_o,
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [DATA_W-1:0] push_data_i,
  input  logic [SLOT_W-1:0] from_slot_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              ok_o,
  output logic [DATA_W-1:0] read_data_o,
  output logic [SLOT_W-1:0] slot_index_o,
  output logic [CNT_W-1:0]  total_count_o,
  output logic [SLOT_W-1:0] first_start_o,
  output logic [CNT_W-1:0]  first_length_o,
  output logic [CNT_W-1:0]  second_start_o,
  output logic [CNT_W-1:0]  second_length_o
);

  localparam logic [CNT_W-1:0] CapMax = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] One    = CNT_W'(1);

  // physical slot of the n-th element from the front
  function automatic logic [CNT_W-1:0] phys(logic [CNT_W-1:0] head,
                                            logic [CNT_W-1:0] cap,
                                            logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] to_wrap;
    to_wrap = cap - head;
    return (n >= to_wrap) ? n - to_wrap : head + n;
  endfunction

  // captured request
  logic [REQ_W-1:0]  req_q;
  logic [DATA_W-1:0] pdata_q;
  logic [SLOT_W-1:0] from_q;

  // ring state
  logic [SLOT_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  cap_q, cap_wr;

  // result held between execute and load
  logic              res_ok_q, res_ok_d;
  logic              res_rd_q, res_rd_d;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;
  logic [CNT_W-1:0]  res_tot_q, res_tot_d;
  logic [CNT_W-1:0]  res_fs_q, res_fs_d;
  logic [CNT_W-1:0]  res_fl_q, res_fl_d;
  logic [CNT_W-1:0]  res_ss_q, res_ss_d;
  logic [CNT_W-1:0]  res_sl_q, res_sl_d;

  logic              mem_we, mem_re;
  logic [DATA_W-1:0] mem_rdata;

  logic              out_valid_q;

  logic [CNT_W-1:0]  head9, from9, ph_fill, ph_last, off, head_prev, nxt;
  logic              not_full, not_empty;
  req_e              req;

  assign req       = req_e'(req_q);
  assign head9     = {1'b0, head_q};
  assign from9     = {1'b0, from_q};
  assign ph_fill   = phys(head9, cap_q, fill_q);
  assign ph_last   = phys(head9, cap_q, fill_q - One);
  assign not_full  = fill_q < cap_q;
  assign not_empty = fill_q != '0;
  assign off       = (from9 >= head9) ? from9 - head9 : from9 + cap_q - head9;
  assign head_prev = (head_q != '0) ? head9 - One : cap_q - One;
  assign nxt       = head9 + One;

  always_comb begin
    head_d     = head_q;
    fill_d     = fill_q;
    res_ok_d   = 1'b0;
    res_rd_d   = 1'b0;
    res_slot_d = '0;
    res_tot_d  = '0;
    res_fs_d   = '0;
    res_fl_d   = '0;
    res_ss_d   = '0;
    res_sl_d   = '0;
    mem_we     = 1'b0;
    case (req)
      REQ_PUSH_BACK: begin
        if (not_full) begin
          res_ok_d   = 1'b1;
          res_slot_d = ph_fill[SLOT_W-1:0];
          fill_d     = fill_q + One;
          mem_we     = 1'b1;
        end
      end
      REQ_PUSH_FRONT: begin
        if (not_full) begin
          res_ok_d   = 1'b1;
          res_slot_d = head_prev[SLOT_W-1:0];
          head_d     = head_prev[SLOT_W-1:0];
          fill_d     = fill_q + One;
          mem_we     = 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (not_empty) begin
          res_ok_d   = 1'b1;
          res_rd_d   = 1'b1;
          res_slot_d = ph_last[SLOT_W-1:0];
          fill_d     = fill_q - One;
        end
      end
      REQ_POP_FRONT: begin
        if (not_empty) begin
          res_ok_d   = 1'b1;
          res_rd_d   = 1'b1;
          res_slot_d = head_q;
          fill_d     = fill_q - One;
          head_d     = (nxt >= cap_q) ? '0 : nxt[SLOT_W-1:0];
        end
      end
      REQ_PEEK_FRONT: begin
        if (not_empty) begin
          res_ok_d   = 1'b1;
          res_rd_d   = 1'b1;
          res_slot_d = head_q;
        end
      end
      REQ_PEEK_BACK: begin
        if (not_empty) begin
          res_ok_d   = 1'b1;
          res_rd_d   = 1'b1;
          res_slot_d = ph_last[SLOT_W-1:0];
        end
      end
      REQ_NEXT: begin
        if (not_empty && from9 < cap_q && off < fill_q && off != fill_q - One) begin
          res_ok_d   = 1'b1;
          res_rd_d   = 1'b1;
          res_slot_d = (from9 + One >= cap_q) ? '0 : from_q + SLOT_W'(1);
        end
      end
      REQ_PREV: begin
        if (not_empty && from9 < cap_q && off < fill_q && off != '0) begin
          res_ok_d   = 1'b1;
          res_rd_d   = 1'b1;
          res_slot_d = (from_q != '0) ? from_q - SLOT_W'(1)
                                      : SLOT_W'(cap_q - One);
        end
      end
      REQ_FREE_REGS: begin
        res_ok_d  = 1'b1;
        res_tot_d = cap_q - fill_q;
        if (!not_full) begin
          res_fs_d = head9;
          res_ss_d = head9;
        end else begin
          res_fs_d = ph_fill;
          if (ph_fill < head9) begin
            res_fl_d = head9 - ph_fill;
            res_ss_d = head9;
          end else begin
            res_fl_d = cap_q - ph_fill;
            res_sl_d = head9;
          end
        end
      end
      REQ_USED_REGS: begin
        res_ok_d  = 1'b1;
        res_tot_d = fill_q;
        res_fs_d  = head9;
        if (!not_empty) begin
          res_ss_d = head9;
        end else if (ph_last < head9) begin
          res_fl_d = cap_q - head9;
          res_sl_d = ph_last + One;
        end else begin
          res_fl_d = ph_last + One - head9;
          res_ss_d = ph_last + One;
        end
      end
      default: begin
      end
    endcase
  end

  assign mem_re = res_rd_d;

  cde_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.exec && mem_we),
    .waddr_i(res_slot_d),
    .wdata_i(pdata_q),
    .re_i   (cmd_i.exec && mem_re),
    .raddr_i(res_slot_d),
    .rdata_o(mem_rdata)
  );

  // clamp capacity to 1..DEPTH
  assign cap_wr = (cfg_wdata_i == '0) ? One :
                  (cfg_wdata_i > CapMax) ? CapMax : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      fill_q      <= '0;
      cap_q       <= CapMax;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q  <= cap_wr;
        head_q <= '0;
        fill_q <= '0;
      end else if (cmd_i.exec) begin
        head_q <= head_d;
        fill_q <= fill_d;
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q   <= req_type_i;
      pdata_q <= push_data_i;
      from_q  <= from_slot_i;
    end
    if (cmd_i.exec) begin
      res_ok_q   <= res_ok_d;
      res_rd_q   <= res_rd_d;
      res_slot_q <= res_slot_d;
      res_tot_q  <= res_tot_d;
      res_fs_q   <= res_fs_d;
      res_fl_q   <= res_fl_d;
      res_ss_q   <= res_ss_d;
      res_sl_q   <= res_sl_d;
    end
    if (cmd_i.load) begin
      ok_o            <= res_ok_q;
      read_data_o     <= res_rd_q ? mem_rdata : '0;
      slot_index_o    <= res_slot_q;
      total_count_o   <= res_tot_q;
      first_start_o   <= res_fs_q[SLOT_W-1:0];
      first_length_o  <= res_fl_q;
      second_start_o  <= res_ss_q;
      second_length_o <= res_sl_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cap_q)
    else $error("fill count above capacity");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head9 < cap_q)
    else $error("head slot outside ring");

  a_cap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_q != '0 && cap_q <= CapMax)
    else $error("capacity out of range");

  a_mem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("write and read issued for one item");

endmodule

// ----- src/circular_deque_engine_top.sv -----
// ----------------------------------------------------------------------------
// Circular deque engine
// Double-ended ring buffer over a 256 x 32 slot memory with stream ports.
// ----------------------------------------------------------------------------
// Each request item (push or pop at either end, peek, step from a slot to its
// neighbor, or a free/used space report) gives exactly one result item. The
// block works on one item at a time: an item goes from accept to result
// through capture, execute with the single memory access, then load of the
// output register after the registered memory read, which waits until the
// output register is free; no new item is taken before that load. The output
// register lets the next item be accepted while the previous result still
// waits for the sink. A failed request returns ok=0 with all other fields zero
// and leaves the ring as is. Writing capacity clamps it to 1..256 and empties
// the ring; write it only while no item is in flight.
// ----------------------------------------------------------------------------
module circular_deque_engine_top
  import cde_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration: capacity
  input  logic                   cfg_we_i,
  input  logic [CNT_W-1:0]       cfg_wdata_i,
  // request stream
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // push_data[31:0], from_slot[39:32]
  input  logic [REQ_W-1:0]       s_axis_tuser_i,  // req_type[3:0]
  // result stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // read_data[31:0], slot_index[39:32], total_count[48:40], first_start[56:49],
  // first_length[65:57], second_start[74:66], second_length[83:75], zero[87:84]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tuser_o   // ok[0]
);

  cde_cmd_t cmd;
  cde_sts_t sts;

  logic [DATA_W-1:0] read_data;
  logic [SLOT_W-1:0] slot_index, first_start;
  logic [CNT_W-1:0]  total_count, first_length, second_start, second_length;

  // sequence capture, execute and load
  cde_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // ring pointers, memory and output register
  cde_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_type_i     (s_axis_tuser_i),
    .push_data_i    (s_axis_tdata_i[31:0]),
    .from_slot_i    (s_axis_tdata_i[39:32]),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .ok_o           (m_axis_tuser_o),
    .read_data_o    (read_data),
    .slot_index_o   (slot_index),
    .total_count_o  (total_count),
    .first_start_o  (first_start),
    .first_length_o (first_length),
    .second_start_o (second_start),
    .second_length_o(second_length)
  );

  // pack result fields, lowest first, zero-fill to whole bytes
  assign m_axis_tdata_o = {4'b0000, second_length, second_start, first_length,
                           first_start, total_count, slot_index, read_data};

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// Circular deque engine testbench
// Drives request items into the deque engine and checks every result item
// against a cycle-free model of the ring kept in the bench, across several
// capacities and idle patterns on both streams.
// ----------------------------------------------------------------------------
module testbench;
  import cde_pkg::*;

  typedef struct packed {
    logic [REQ_W-1:0]  op;
    logic [DATA_W-1:0] value;
    logic [SLOT_W-1:0] from_slot;
  } deque_req_t;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] read_data;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  total;
    logic [SLOT_W-1:0] first_start;
    logic [CNT_W-1:0]  first_len;
    logic [CNT_W-1:0]  second_start;
    logic [CNT_W-1:0]  second_len;
  } deque_result_t;

  // Request codes above the last defined one are unknown to the block.
  localparam int LAST_REQ = REQ_USED_REGS;
  localparam int TOP_CODE = (1 << REQ_W) - 1;
  localparam int DRAIN_CYCLES = 6;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CNT_W-1:0]       cfg_wdata = '0;
  logic                   req_tvalid = 1'b0;
  logic                   req_tready;
  logic [IN_TDATA_W-1:0]  req_tdata = '0;
  logic [REQ_W-1:0]       req_tuser = '0;
  logic                   res_tvalid;
  logic                   res_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] res_tdata;
  logic                   res_tuser;

  circular_deque_engine_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (req_tvalid),
    .s_axis_tready_o (req_tready),
    .s_axis_tdata_i  (req_tdata),
    .s_axis_tuser_i  (req_tuser),
    .m_axis_tvalid_o (res_tvalid),
    .m_axis_tready_i (res_tready),
    .m_axis_tdata_o  (res_tdata),
    .m_axis_tuser_o  (res_tuser)
  );

  // Ring state as the bench sees it
  logic [DATA_W-1:0] ring_mem [DEPTH];
  int ring_cap  = DEPTH;
  int ring_head = 0;
  int ring_fill = 0;

  deque_req_t    pending_reqs [$];
  deque_result_t expected_results [$];

  int items_queued   = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int results_ok     = 0;
  int error_count    = 0;
  int cap_settings   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int gen_cap        = DEPTH;
  bit req_accepted   = 1'b0;

  // Free-running clock
  initial begin
    forever #10 clk = ~clk;
  end

  // End the run if it hangs
  initial begin
    #6_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(string msg);
    error_count++;
    $display("tb: mismatch at result %0d: %s", results_seen, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // Physical slot of the n-th element counted from the front
  function automatic int slot_at(int n);
    int to_wrap;
    to_wrap = ring_cap - ring_head;
    return (n >= to_wrap) ? n - to_wrap : ring_head + n;
  endfunction

  // Apply one request to the ring and return the result it must produce
  function automatic deque_result_t deque_apply(deque_req_t r);
    deque_result_t res;
    int from;
    int off;
    int s;
    res  = '0;
    from = int'(r.from_slot);
    case (r.op)
      REQ_PUSH_BACK: begin
        if (ring_fill < ring_cap) begin
          ring_fill++;
          s = slot_at(ring_fill - 1);
          ring_mem[s] = r.value;
          res.slot = SLOT_W'(s);
          res.ok = 1'b1;
        end
      end
      REQ_PUSH_FRONT: begin
        if (ring_fill < ring_cap) begin
          ring_head = (ring_head != 0) ? ring_head - 1 : ring_cap - 1;
          ring_fill++;
          ring_mem[ring_head] = r.value;
          res.slot = SLOT_W'(ring_head);
          res.ok = 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (ring_fill != 0) begin
          ring_fill--;
          s = slot_at(ring_fill);
          res.read_data = ring_mem[s];
          res.slot = SLOT_W'(s);
          res.ok = 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (ring_fill != 0) begin
          res.read_data = ring_mem[ring_head];
          res.slot = SLOT_W'(ring_head);
          ring_fill--;
          ring_head = (ring_head + 1 >= ring_cap) ? 0 : ring_head + 1;
          res.ok = 1'b1;
        end
      end
      REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
        if (ring_fill != 0) begin
          s = (r.op == REQ_PEEK_FRONT) ? ring_head : slot_at(ring_fill - 1);
          res.read_data = ring_mem[s];
          res.slot = SLOT_W'(s);
          res.ok = 1'b1;
        end
      end
      REQ_NEXT, REQ_PREV: begin
        if (ring_fill != 0 && from < ring_cap) begin
          off = (from >= ring_head) ? from - ring_head : from + ring_cap - ring_head;
          if (off < ring_fill) begin
            // Stepping off either end of the used region fails
            if (r.op == REQ_NEXT && off != ring_fill - 1) begin
              s = (from + 1 >= ring_cap) ? 0 : from + 1;
              res.ok = 1'b1;
            end else if (r.op == REQ_PREV && off != 0) begin
              s = (from != 0) ? from - 1 : ring_cap - 1;
              res.ok = 1'b1;
            end
            if (res.ok) begin
              res.read_data = ring_mem[s];
              res.slot = SLOT_W'(s);
            end
          end
        end
      end
      REQ_FREE_REGS: begin
        res.ok = 1'b1;
        res.total = CNT_W'(ring_cap - ring_fill);
        if (ring_fill == ring_cap) begin
          res.first_start = SLOT_W'(ring_head);
          res.second_start = CNT_W'(ring_head);
        end else begin
          s = slot_at(ring_fill);
          res.first_start = SLOT_W'(s);
          if (s < ring_head) begin
            res.first_len = CNT_W'(ring_head - s);
            res.second_start = CNT_W'(ring_head);
          end else begin
            res.first_len = CNT_W'(ring_cap - s);
            res.second_len = CNT_W'(ring_head);
          end
        end
      end
      REQ_USED_REGS: begin
        res.ok = 1'b1;
        res.total = CNT_W'(ring_fill);
        res.first_start = SLOT_W'(ring_head);
        if (ring_fill == 0) begin
          res.second_start = CNT_W'(ring_head);
        end else begin
          s = slot_at(ring_fill - 1);
          if (s < ring_head) begin
            res.first_len = CNT_W'(ring_cap - ring_head);
            res.second_len = CNT_W'(s + 1);
          end else begin
            res.first_len = CNT_W'(s + 1 - ring_head);
            res.second_start = CNT_W'(s + 1);
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Monitor: track config writes, predict on request accept, check on result accept
  always @(posedge clk) begin : monitor
    deque_req_t    req;
    deque_result_t got;
    deque_result_t want;
    req_accepted = 1'b0;
    if (rst_n) begin
      if (cfg_we) begin
        ring_cap  = (int'(cfg_wdata) < 1) ? 1 :
                    (int'(cfg_wdata) > DEPTH) ? DEPTH : int'(cfg_wdata);
        ring_head = 0;
        ring_fill = 0;
      end
      if (req_tvalid && req_tready) begin
        req.op        = req_tuser;
        req.value     = req_tdata[31:0];
        req.from_slot = req_tdata[39:32];
        expected_results.push_back(deque_apply(req));
        items_accepted++;
        req_accepted = 1'b1;
      end
      if (res_tvalid && res_tready) begin
        results_seen++;
        got.ok           = res_tuser;
        got.read_data    = res_tdata[31:0];
        got.slot         = res_tdata[39:32];
        got.total        = res_tdata[48:40];
        got.first_start  = res_tdata[56:49];
        got.first_len    = res_tdata[65:57];
        got.second_start = res_tdata[74:66];
        got.second_len   = res_tdata[83:75];
        if (expected_results.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = expected_results.pop_front();
          results_ok += int'(want.ok);
          check_field("ok", 32'(got.ok), 32'(want.ok));
          check_field("read_data", got.read_data, want.read_data);
          check_field("slot_index", 32'(got.slot), 32'(want.slot));
          check_field("total_count", 32'(got.total), 32'(want.total));
          check_field("first_start", 32'(got.first_start), 32'(want.first_start));
          check_field("first_length", 32'(got.first_len), 32'(want.first_len));
          check_field("second_start", 32'(got.second_start), 32'(want.second_start));
          check_field("second_length", 32'(got.second_len), 32'(want.second_len));
        end
      end
    end
  end

  // Driver: present the next pending item once the current one is taken
  always @(negedge clk) begin : driver
    deque_req_t nxt;
    if (!req_tvalid || req_accepted) begin
      if (rst_n && pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_reqs.pop_front();
        req_tvalid <= 1'b1;
        req_tdata  <= {nxt.from_slot, nxt.value};
        req_tuser  <= nxt.op;
      end else begin
        req_tvalid <= 1'b0;
      end
    end
    res_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic queue_req(int op, logic [DATA_W-1:0] value, int from);
    deque_req_t r;
    r.op        = REQ_W'(op);
    r.value     = value;
    r.from_slot = SLOT_W'(from);
    pending_reqs.push_back(r);
    items_queued++;
  endtask

  // Hold until every queued item has come back
  task automatic wait_drained();
    while (results_seen < items_queued) @(negedge clk);
  endtask

  // Only write while idle; let the pipeline settle first
  task automatic write_capacity(int value);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wdata = CNT_W'(value);
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    gen_cap = (value < 1) ? 1 : (value > DEPTH) ? DEPTH : value;
    cap_settings++;
  endtask

  // Random traffic in fill and drain bursts so the ring reaches full and empty
  task automatic queue_random(int count);
    int i;
    int roll;
    int burst;
    int op;
    int from;
    bit filling;
    burst = 0;
    filling = 1'b1;
    for (i = 0; i < count; i++) begin
      if (burst == 0) begin
        filling = ~filling;
        burst = $urandom_range(4, (3 * gen_cap + 8 > 300) ? 300 : 3 * gen_cap + 8);
      end
      burst--;
      roll = $urandom_range(99);
      if (roll < (filling ? 55 : 10)) begin
        op = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
      end else if (roll < (filling ? 62 : 55)) begin
        op = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
      end else if (roll < 72) begin
        op = $urandom_range(1) ? REQ_PEEK_FRONT : REQ_PEEK_BACK;
      end else if (roll < 87) begin
        op = $urandom_range(1) ? REQ_NEXT : REQ_PREV;
      end else if (roll < 98) begin
        op = $urandom_range(1) ? REQ_FREE_REGS : REQ_USED_REGS;
      end else begin
        op = $urandom_range(TOP_CODE, LAST_REQ + 1);
      end
      // Aim steps mostly inside the ring, sometimes anywhere
      from = ($urandom_range(3) == 0) ? $urandom_range(DEPTH - 1) : $urandom_range(gen_cap - 1);
      queue_req(op, $urandom(), from);
    end
  endtask

  task automatic run_phase(int cap, int send_pct, int recv_pct, int count);
    write_capacity(cap);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_random(count);
    wait_drained();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Empty ring at the reset capacity: everything but pushes and reports fails
    queue_req(REQ_POP_BACK, '0, 0);
    queue_req(REQ_POP_FRONT, '0, 0);
    queue_req(REQ_PEEK_FRONT, '0, 0);
    queue_req(REQ_PEEK_BACK, '0, 0);
    queue_req(REQ_NEXT, '0, 0);
    queue_req(REQ_USED_REGS, '0, 0);
    queue_req(REQ_FREE_REGS, '0, 0);
    queue_req(TOP_CODE, '1, DEPTH - 1);
    queue_req(REQ_PUSH_BACK, '0, 0);
    wait_drained();

    // Three-slot ring: wrap the head, hit full, step at and past both ends
    write_capacity(3);
    queue_req(REQ_PUSH_FRONT, '1, DEPTH - 1);
    queue_req(REQ_PUSH_BACK, '0, 0);
    queue_req(REQ_PUSH_BACK, 32'h5a5a_a5a5, 0);
    queue_req(REQ_PUSH_FRONT, 32'h1234_5678, 0);
    queue_req(REQ_PUSH_BACK, 32'h8765_4321, 0);
    queue_req(REQ_FREE_REGS, '0, 0);
    queue_req(REQ_USED_REGS, '0, 0);
    queue_req(REQ_NEXT, '0, 1);
    queue_req(REQ_PREV, '0, 2);
    queue_req(REQ_NEXT, '0, 2);
    queue_req(REQ_PREV, '0, 0);
    queue_req(REQ_NEXT, '0, DEPTH - 1);
    queue_req(REQ_PEEK_BACK, '0, 0);
    queue_req(REQ_PEEK_FRONT, '0, 0);
    queue_req(REQ_POP_BACK, '0, 0);
    queue_req(REQ_POP_FRONT, '0, 0);
    queue_req(REQ_FREE_REGS, '0, 0);
    queue_req(LAST_REQ + 1, '0, 0);
    wait_drained();

    // Random phases: capacity written each time, zero and over-range included
    run_phase(0, 0, 0, 150);
    run_phase(2, 49, 0, 200);
    run_phase(7, 0, 49, 250);
    run_phase(16, 17, 17, 250);
    run_phase(511, 0, 0, 400);
    run_phase(DEPTH, 17, 17, 150);
    run_phase(33, 49, 0, 250);
    run_phase(3, 0, 49, 150);

    repeat (DRAIN_CYCLES) @(negedge clk);
    while (expected_results.size() > 0) begin
      void'(expected_results.pop_front());
      report_mismatch("expected result never arrived");
    end

    $display("tb: %0d requests accepted, %0d results checked, %0d of them served",
             items_accepted, results_seen, results_ok);
    $display("tb: %0d capacity settings from 1 to %0d slots, %0d mismatches",
             cap_settings, DEPTH, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
